// ----- rtl/core/swcc_pkg.sv -----
// Shared types and constants for the segment wall collision checker.
// No dependencies; imported by swcc_ctrl, swcc_datapath and the top level.
package swcc_pkg;

  // Item opcodes
  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Configuration register indexes
  localparam int   CFG_IDX_BITS     = 1;
  localparam logic CFG_ARENA_WIDTH  = 1'b0;
  localparam logic CFG_ARENA_HEIGHT = 1'b1;

  localparam int               ARENA_BITS  = 12;
  localparam logic [11:0]      ARENA_RESET = 12'd4095;

  // Orientation of an ordered point triple
  typedef enum logic [1:0] {
    ORI_COL = 2'd0,
    ORI_CW  = 2'd1,
    ORI_CCW = 2'd2
  } swcc_ori_e;

  // Controller -> datapath
  typedef struct packed {
    logic accept;    // input transaction this cycle
    logic issue;     // read next wall and push it down the pipe
    logic load_out;  // capture result into output register
  } swcc_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic in_query;    // offered item is a query
    logic in_skip;     // offered query needs no wall scan
    logic last_issue;  // current issue reads the last stored wall
    logic pipe_busy;   // a wall is still in the test pipe
  } swcc_status_t;

endpackage

// ----- rtl/core/segment_wall_collision_check.sv -----
// Flow: an add, an out-of-bounds query or a query on an empty table goes straight
//   to the result; other queries first scan the N stored walls and drain the pipe.
// Throughput: one item at a time; a query's scan reads one wall per cycle from a
//   single-port wall memory into a 4-stage orientation test pipe.
// Reset (rst_ni async, low): wall count 0, arena width/height 4095, no result pending.
//   The wall memory itself is not cleared; only written entries are ever read.
module segment_wall_collision_check #(
  parameter int MAX_WALLS  = 64,
  parameter int COORD_BITS = 13
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // config write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [swcc_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [swcc_pkg::ARENA_BITS-1:0]     cfg_data_i,
  // item channel
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                opcode_i,
  input  logic signed [COORD_BITS-1:0]        point_a_x_i,
  input  logic signed [COORD_BITS-1:0]        point_a_y_i,
  input  logic signed [COORD_BITS-1:0]        point_b_x_i,
  input  logic signed [COORD_BITS-1:0]        point_b_y_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                collision_o,
  output logic                                out_of_bounds_o,
  output logic                                table_full_o
);
  import swcc_pkg::*;

  swcc_cmd_t    cmd;
  swcc_status_t status;

  // Config takes a write every cycle; user must write only while idle, not enforced.
  assign cfg_ready_o = 1'b1;

  // Controller: IDLE -> (SCAN -> DRAIN) -> RESULT. The result register sits
  // between the scan and the output so a new transaction is taken while the
  // previous result is still waiting on out_ready_i.
  swcc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Datapath: adds write the wall memory at accept if the table is not full;
  // queries check bounds at accept, then stream stored walls through read / diff /
  // multiply / sign stages and OR the per-wall hits.
  swcc_datapath #(
    .MAX_WALLS  (MAX_WALLS),
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .opcode_i        (opcode_i),
    .point_a_x_i     (point_a_x_i),
    .point_a_y_i     (point_a_y_i),
    .point_b_x_i     (point_b_x_i),
    .point_b_y_i     (point_b_y_i),
    .collision_o     (collision_o),
    .out_of_bounds_o (out_of_bounds_o),
    .table_full_o    (table_full_o)
  );

endmodule

// ----- rtl/core/swcc_ctrl.sv -----
// Sequencer for the wall collision checker: item flow and output handshake.
// Depends on swcc_pkg.
module swcc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  swcc_pkg::swcc_status_t status_i,
  output swcc_pkg::swcc_cmd_t    cmd_o
);
  import swcc_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DRAIN  = 2'd2;
  localparam logic [1:0] S_RESULT = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o.accept   = in_valid_i && (state_q == S_IDLE);
    cmd_o.issue    = (state_q == S_SCAN);
    cmd_o.load_out = (state_q == S_RESULT) && out_free;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (status_i.in_query && !status_i.in_skip) begin
            state_d = S_SCAN;
          end else begin
            state_d = S_RESULT;
          end
        end
      end
      S_SCAN: begin
        if (status_i.last_issue) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!status_i.pipe_busy) begin
          state_d = S_RESULT;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTHESIS
  a_result_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESULT && out_free) |=> out_valid_q)
    else $error("result not presented after load");

  a_scan_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && status_i.last_issue) |=> (state_q == S_DRAIN))
    else $error("scan did not stop after last wall");
`endif

endmodule

// ----- rtl/core/swcc_datapath.sv -----
// Datapath: config registers, wall memory, four-stage orientation test pipe,
// bounds check and result registers. Depends on swcc_pkg.
module swcc_datapath #(
  parameter int MAX_WALLS  = 64,
  parameter int COORD_BITS = 13
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  swcc_pkg::swcc_cmd_t                 cmd_i,
  output swcc_pkg::swcc_status_t              status_o,
  input  logic                                cfg_valid_i,
  input  logic [swcc_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [swcc_pkg::ARENA_BITS-1:0]     cfg_data_i,
  input  logic                                opcode_i,
  input  logic signed [COORD_BITS-1:0]        point_a_x_i,
  input  logic signed [COORD_BITS-1:0]        point_a_y_i,
  input  logic signed [COORD_BITS-1:0]        point_b_x_i,
  input  logic signed [COORD_BITS-1:0]        point_b_y_i,
  output logic                                collision_o,
  output logic                                out_of_bounds_o,
  output logic                                table_full_o
);
  import swcc_pkg::*;

  localparam int AW   = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1;
  localparam int CNTW = $clog2(MAX_WALLS + 1);
  localparam int CW   = COORD_BITS;
  localparam int DW   = CW + 1;           // coordinate difference
  localparam int PW   = 2 * DW;           // product
  localparam int VW   = PW + 1;           // cross product
  localparam int XW   = ((CW > ARENA_BITS) ? CW : ARENA_BITS) + 1;
  localparam int EW   = 4 * CW;           // one stored wall

  function automatic logic signed [DW-1:0] diff(input logic signed [CW-1:0] a,
                                                input logic signed [CW-1:0] b);
    return DW'(a) - DW'(b);
  endfunction

  // point p inside bounding box of a-b
  function automatic logic in_box(input logic signed [CW-1:0] px,
                                  input logic signed [CW-1:0] py,
                                  input logic signed [CW-1:0] ax,
                                  input logic signed [CW-1:0] ay,
                                  input logic signed [CW-1:0] bx,
                                  input logic signed [CW-1:0] by);
    return (px >= ax || px >= bx) && (px <= ax || px <= bx) &&
           (py >= ay || py >= by) && (py <= ay || py <= by);
  endfunction

  // config
  logic [ARENA_BITS-1:0] arena_w_q, arena_h_q;

  // table state
  logic [EW-1:0]   wall_mem [MAX_WALLS];
  logic [CNTW-1:0] count_q;
  logic            table_full;
  logic            add_ok;

  // current item
  logic signed [CW-1:0] m_ax_q, m_ay_q, m_bx_q, m_by_q;
  logic                 query_q, oob_q, full_q, hit_q;
  logic                 oob_now;

  // scan and pipe
  logic [AW-1:0]        scan_q;
  logic [EW-1:0]        rd_q;
  logic                 va_q, vb_q, vc_q;
  logic signed [CW-1:0] w_ax, w_ay, w_bx, w_by;
  logic signed [DW-1:0] dir_x_d [4], dir_y_d [4], rel_x_d [4], rel_y_d [4];
  logic signed [DW-1:0] dir_x_q [4], dir_y_q [4], rel_x_q [4], rel_y_q [4];
  logic [3:0]           box_d, box_b_q, box_c_q;
  logic signed [PW-1:0] prod_a_q [4], prod_b_q [4];
  logic signed [VW-1:0] cross_v [4];
  swcc_ori_e            ori [4];
  logic                 hit;

  // ---------------- config ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arena_w_q <= ARENA_RESET;
      arena_h_q <= ARENA_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ARENA_WIDTH:  arena_w_q <= cfg_data_i;
        CFG_ARENA_HEIGHT: arena_h_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // ---------------- accept ----------------
  assign table_full = (count_q == CNTW'(MAX_WALLS));
  assign add_ok     = cmd_i.accept && (opcode_i == OP_ADD) && !table_full;

  assign oob_now = point_b_x_i[CW-1] || point_b_y_i[CW-1] ||
                   (XW'(point_b_x_i) >= $signed(XW'(arena_w_q))) ||
                   (XW'(point_b_y_i) >= $signed(XW'(arena_h_q)));

  always_ff @(posedge clk_i) begin
    if (add_ok) begin
      wall_mem[count_q[AW-1:0]] <= {point_a_x_i, point_a_y_i, point_b_x_i, point_b_y_i};
    end
    if (cmd_i.issue) begin
      rd_q <= wall_mem[scan_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (add_ok) begin
      count_q <= count_q + CNTW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      m_ax_q  <= point_a_x_i;
      m_ay_q  <= point_a_y_i;
      m_bx_q  <= point_b_x_i;
      m_by_q  <= point_b_y_i;
      query_q <= (opcode_i == OP_QUERY);
      oob_q   <= oob_now;
      full_q  <= table_full;
    end
  end

  // ---------------- scan counter ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= '0;
    end else if (cmd_i.accept) begin
      scan_q <= '0;
    end else if (cmd_i.issue) begin
      scan_q <= scan_q + AW'(1);
    end
  end

  // ---------------- pipe valids ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      va_q <= cmd_i.issue;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  // ---------------- stage B: differences, boxes ----------------
  assign w_ax = rd_q[EW-1 -: CW];
  assign w_ay = rd_q[EW-CW-1 -: CW];
  assign w_bx = rd_q[2*CW-1 -: CW];
  assign w_by = rd_q[CW-1 -: CW];

  always_comb begin
    // turn(p,q,r) = (qy-py)*(rx-qx) - (qx-px)*(ry-qy)
    dir_x_d[0] = diff(m_bx_q, m_ax_q);  dir_y_d[0] = diff(m_by_q, m_ay_q);
    dir_x_d[1] = dir_x_d[0];            dir_y_d[1] = dir_y_d[0];
    dir_x_d[2] = diff(w_bx, w_ax);      dir_y_d[2] = diff(w_by, w_ay);
    dir_x_d[3] = dir_x_d[2];            dir_y_d[3] = dir_y_d[2];
    rel_x_d[0] = diff(w_ax, m_bx_q);    rel_y_d[0] = diff(w_ay, m_by_q);
    rel_x_d[1] = diff(w_bx, m_bx_q);    rel_y_d[1] = diff(w_by, m_by_q);
    rel_x_d[2] = diff(m_ax_q, w_bx);    rel_y_d[2] = diff(m_ay_q, w_by);
    rel_x_d[3] = diff(m_bx_q, w_bx);    rel_y_d[3] = diff(m_by_q, w_by);
    box_d[0] = in_box(w_ax, w_ay, m_ax_q, m_ay_q, m_bx_q, m_by_q);
    box_d[1] = in_box(w_bx, w_by, m_ax_q, m_ay_q, m_bx_q, m_by_q);
    box_d[2] = in_box(m_ax_q, m_ay_q, w_ax, w_ay, w_bx, w_by);
    box_d[3] = in_box(m_bx_q, m_by_q, w_ax, w_ay, w_bx, w_by);
  end

  always_ff @(posedge clk_i) begin
    dir_x_q <= dir_x_d;
    dir_y_q <= dir_y_d;
    rel_x_q <= rel_x_d;
    rel_y_q <= rel_y_d;
    box_b_q <= box_d;
  end

  // ---------------- stage C: products ----------------
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 4; k++) begin
      prod_a_q[k] <= PW'(dir_y_q[k]) * PW'(rel_x_q[k]);
      prod_b_q[k] <= PW'(dir_x_q[k]) * PW'(rel_y_q[k]);
    end
    box_c_q <= box_b_q;
  end

  // ---------------- stage D: orientations, hit ----------------
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      cross_v[k] = VW'(prod_a_q[k]) - VW'(prod_b_q[k]);
      if (cross_v[k] == '0) begin
        ori[k] = ORI_COL;
      end else if (!cross_v[k][VW-1]) begin
        ori[k] = ORI_CW;
      end else begin
        ori[k] = ORI_CCW;
      end
    end
    hit = ((ori[0] != ori[1]) && (ori[2] != ori[3])) ||
          ((ori[0] == ORI_COL) && box_c_q[0]) ||
          ((ori[1] == ORI_COL) && box_c_q[1]) ||
          ((ori[2] == ORI_COL) && box_c_q[2]) ||
          ((ori[3] == ORI_COL) && box_c_q[3]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (cmd_i.accept) begin
      hit_q <= 1'b0;
    end else if (vc_q && hit) begin
      hit_q <= 1'b1;
    end
  end

  // ---------------- result ----------------
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      collision_o     <= query_q && (oob_q || hit_q);
      out_of_bounds_o <= query_q && oob_q;
      table_full_o    <= !query_q && full_q;
    end
  end

  always_comb begin
    status_o.in_query   = (opcode_i == OP_QUERY);
    status_o.in_skip    = oob_now || (count_q == '0);
    status_o.last_issue = ((CNTW'(scan_q) + CNTW'(1)) == count_q);
    status_o.pipe_busy  = va_q || vb_q || vc_q;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNTW'(MAX_WALLS))
    else $error("wall count beyond table depth");

  a_pipe_empty_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.accept |-> !(va_q || vb_q || vc_q))
    else $error("transaction accepted while test pipe busy");
`endif

endmodule

// ----- dv/tb_segment_wall_collision_check.sv -----
// Self-checking testbench for segment_wall_collision_check: wall adds and move queries.
// Depends on swcc_pkg and the RTL top level; expected verdicts come from a built-in predictor.
`timescale 1ns / 1ps

module tb_segment_wall_collision_check;
  import swcc_pkg::*;

  localparam int     MAX_WALLS      = 64;
  localparam int     COORD_BITS     = 13;
  localparam longint COORD_MAX      = 4095;
  localparam longint COORD_MIN      = -4096;
  // Cycles with no transaction on any channel before the run is declared hung.
  // Covers the long receiver hold-off, the longest sender gap and a full scan.
  localparam int     WATCHDOG_LIMIT = 3000;
  // Drain time after the last result: a full 64-wall scan plus pipe margin.
  localparam int     DRAIN_CYCLES   = 80;
  localparam int     HOLD_CYCLES    = 300;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct {
    logic   op;
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by;
  } coord_item_t;

  typedef struct packed {
    logic collision;
    logic out_of_bounds;
    logic table_full;
  } verdict_t;

  // Random phases: arena setting and number of items. Extremes get short phases.
  localparam int PHASES = 9;
  localparam int PH_W[PHASES]   = '{4095, 1000,    0, 4095, 1,  600, 4095, 2048, 4095};
  localparam int PH_H[PHASES]   = '{4095,  800, 4095,    0, 1,  500,    1, 3000, 4095};
  localparam int PH_LEN[PHASES] = '{ 120,  120,   25,   25, 30, 100,   20,  120,   60};

  logic clk;
  logic rst_ni = 1'b0;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = CFG_ARENA_WIDTH;
  logic [ARENA_BITS-1:0] cfg_data  = '0;

  logic   in_valid = 1'b0;
  logic   in_ready;
  logic   opcode   = OP_ADD;
  coord_t pa_x     = '0;
  coord_t pa_y     = '0;
  coord_t pb_x     = '0;
  coord_t pb_y     = '0;

  logic out_valid;
  logic out_ready = 1'b0;
  logic collision;
  logic out_of_bounds;
  logic table_full;

  segment_wall_collision_check #(
    .MAX_WALLS  (MAX_WALLS),
    .COORD_BITS (COORD_BITS)
  ) DUT (
    .clk_i           (clk),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .opcode_i        (opcode),
    .point_a_x_i     (pa_x),
    .point_a_y_i     (pa_y),
    .point_b_x_i     (pb_x),
    .point_b_y_i     (pb_y),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .collision_o     (collision),
    .out_of_bounds_o (out_of_bounds),
    .table_full_o    (table_full)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shared state
  // ---------------------------------------------------------------------------
  coord_item_t pending_items[$];     // items waiting for the driver
  coord_item_t gen_walls[$];         // walls issued so far, used to aim queries
  verdict_t    expected_verdicts[$]; // predicted results, oldest first

  int   errors        = 0;
  int   verdicts_seen = 0;
  int   idle_cycles   = 0;
  logic in_took       = 1'b0;  // item transaction at the last rising edge
  logic calm          = 1'b0;  // phase with no idling on either side

  int in_gap     = 0;
  int stall_left = 0;
  int hold_left  = 0;
  bit hold_done  = 1'b0;

  // Predictor state: own copy of the wall store and the arena registers
  longint wall_ax[MAX_WALLS];
  longint wall_ay[MAX_WALLS];
  longint wall_bx[MAX_WALLS];
  longint wall_by[MAX_WALLS];
  int     wall_cnt     = 0;
  int     arena_w      = ARENA_RESET;
  int     arena_h      = ARENA_RESET;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic swcc_ori_e turn_of(longint px, longint py, longint qx, longint qy,
                                        longint rx, longint ry);
    longint v;
    v = (qy - py) * (rx - qx) - (qx - px) * (ry - qy);
    if (v == 0) return ORI_COL;
    return (v > 0) ? ORI_CW : ORI_CCW;
  endfunction

  // Point inside the bounding box of segment a-b
  function automatic bit in_box(longint px, longint py, longint ax, longint ay,
                                longint bx, longint by);
    return px >= ((ax < bx) ? ax : bx) && px <= ((ax > bx) ? ax : bx) &&
           py >= ((ay < by) ? ay : by) && py <= ((ay > by) ? ay : by);
  endfunction

  // Four-orientation test; collinear touch and overlap count as a hit
  function automatic bit segments_touch(longint max_, longint may, longint mbx, longint mby,
                                        longint wax, longint way, longint wbx, longint wby);
    swcc_ori_e o1, o2, o3, o4;
    o1 = turn_of(max_, may, mbx, mby, wax, way);
    o2 = turn_of(max_, may, mbx, mby, wbx, wby);
    o3 = turn_of(wax, way, wbx, wby, max_, may);
    o4 = turn_of(wax, way, wbx, wby, mbx, mby);
    if (o1 != o2 && o3 != o4) return 1'b1;
    if (o1 == ORI_COL && in_box(wax, way, max_, may, mbx, mby)) return 1'b1;
    if (o2 == ORI_COL && in_box(wbx, wby, max_, may, mbx, mby)) return 1'b1;
    if (o3 == ORI_COL && in_box(max_, may, wax, way, wbx, wby)) return 1'b1;
    if (o4 == ORI_COL && in_box(mbx, mby, wax, way, wbx, wby)) return 1'b1;
    return 1'b0;
  endfunction

  // Updates the wall store on an add and returns the verdict of one item
  function automatic verdict_t predict_verdict(coord_item_t it);
    verdict_t v;
    longint   ax, ay, bx, by;
    v  = '0;
    ax = longint'(it.ax);
    ay = longint'(it.ay);
    bx = longint'(it.bx);
    by = longint'(it.by);
    if (it.op == OP_ADD) begin
      if (wall_cnt >= MAX_WALLS) begin
        v.table_full = 1'b1;
      end else begin
        wall_ax[wall_cnt] = ax;
        wall_ay[wall_cnt] = ay;
        wall_bx[wall_cnt] = bx;
        wall_by[wall_cnt] = by;
        wall_cnt++;
      end
    end else if (bx < 0 || bx >= arena_w || by < 0 || by >= arena_h) begin
      v.collision     = 1'b1;
      v.out_of_bounds = 1'b1;
    end else begin
      for (int i = 0; i < wall_cnt; i++) begin
        if (segments_touch(ax, ay, bx, by, wall_ax[i], wall_ay[i], wall_bx[i], wall_by[i])) begin
          v.collision = 1'b1;
          break;
        end
      end
    end
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic coord_t clip(longint v);
    if (v > COORD_MAX) v = COORD_MAX;
    if (v < COORD_MIN) v = COORD_MIN;
    return v[COORD_BITS-1:0];
  endfunction

  function automatic int spread(int r);
    return int'($urandom_range(0, 2 * r)) - r;
  endfunction

  // Mostly short gaps, a few long ones; none in a calm phase
  function automatic int pick_gap();
    int p;
    if (calm) return 0;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  // One random item. Walls cluster near the origin so that queries hit and miss;
  // some queries are aimed at issued walls to reach the collinear cases.
  function automatic coord_item_t gen_item(int aw, int ah);
    coord_item_t it, w;
    int          pick, s, t;
    longint      ox, oy, dx, dy;
    pick = $urandom_range(0, 99);
    ox   = longint'($urandom_range(0, 700));
    oy   = longint'($urandom_range(0, 700));
    it.op = ($urandom_range(0, 99) < 20) ? OP_ADD : OP_QUERY;
    if (it.op == OP_ADD) begin
      if (pick < 60) begin
        it.ax = clip(ox);
        it.ay = clip(oy);
        it.bx = clip(ox + spread(40));
        it.by = clip(oy + spread(40));
      end else if (pick < 75) begin
        it.ax = clip(ox);
        it.ay = clip(oy);
        it.bx = (pick < 68) ? clip(ox + spread(120)) : clip(ox);
        it.by = (pick < 68) ? clip(oy) : clip(oy + spread(120));
      end else if (pick < 88) begin
        it.ax = clip(ox);  // zero-length wall
        it.ay = clip(oy);
        it.bx = it.ax;
        it.by = it.ay;
      end else begin
        it.ax = coord_t'($urandom());
        it.ay = coord_t'($urandom());
        it.bx = coord_t'($urandom());
        it.by = coord_t'($urandom());
      end
      gen_walls = {gen_walls, it};
    end else if (pick < 40) begin
      it.ax = clip(ox);
      it.ay = clip(oy);
      it.bx = clip(ox + spread(60));
      it.by = clip(oy + spread(60));
    end else if (pick < 55 && gen_walls.size() > 0) begin
      // on the line of a wall: overlap, touch or disjoint
      w  = gen_walls[$urandom_range(0, gen_walls.size() - 1)];
      dx = longint'(w.bx) - longint'(w.ax);
      dy = longint'(w.by) - longint'(w.ay);
      s  = int'($urandom_range(0, 3)) - 1;
      t  = int'($urandom_range(0, 3)) - 1;
      it.ax = clip(longint'(w.ax) + s * dx);
      it.ay = clip(longint'(w.ay) + s * dy);
      it.bx = clip(longint'(w.ax) + t * dx);
      it.by = clip(longint'(w.ay) + t * dy);
    end else if (pick < 65 && gen_walls.size() > 0) begin
      // move ends on a wall endpoint
      w     = gen_walls[$urandom_range(0, gen_walls.size() - 1)];
      it.ax = clip(ox);
      it.ay = clip(oy);
      it.bx = pick[0] ? w.ax : w.bx;
      it.by = pick[0] ? w.ay : w.by;
    end else if (pick < 75) begin
      // end just outside one arena edge
      it.ax = clip(ox);
      it.ay = clip(oy);
      it.bx = clip(longint'($urandom_range(0, (aw > 0) ? aw - 1 : 0)));
      it.by = clip(longint'($urandom_range(0, (ah > 0) ? ah - 1 : 0)));
      case ($urandom_range(0, 3))
        0:       it.bx = clip(-1 - longint'($urandom_range(0, 20)));
        1:       it.bx = clip(aw + longint'($urandom_range(0, 20)));
        2:       it.by = clip(-1 - longint'($urandom_range(0, 20)));
        default: it.by = clip(ah + longint'($urandom_range(0, 20)));
      endcase
    end else if (pick < 82) begin
      // end on an inside corner of the arena
      it.ax = clip(ox);
      it.ay = clip(oy);
      it.bx = pick[0] ? clip(aw - 1) : '0;
      it.by = pick[1] ? clip(ah - 1) : '0;
    end else begin
      it.ax = coord_t'($urandom());
      it.ay = coord_t'($urandom());
      it.bx = coord_t'($urandom());
      it.by = coord_t'($urandom());
    end
    return it;
  endfunction

  task automatic push_item(logic op, longint ax, longint ay, longint bx, longint by);
    coord_item_t it;
    it.op = op;
    it.ax = clip(ax);
    it.ay = clip(ay);
    it.bx = clip(bx);
    it.by = clip(by);
    if (op == OP_ADD) gen_walls = {gen_walls, it};
    pending_items = {pending_items, it};
  endtask

  // Block is idle once every item is taken and every verdict has returned
  task automatic wait_quiet(int extra);
    while (!(pending_items.size() == 0 && !in_valid && expected_verdicts.size() == 0))
      @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // Register write; the predictor copy follows on the write transaction
  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, int val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[ARENA_BITS-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_ARENA_WIDTH) arena_w = val;
    else                        arena_h = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed items on reset arena, then random phases
  // ---------------------------------------------------------------------------
  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;
    @(negedge clk);

    // empty table and out-of-bounds edges, coordinate extremes
    push_item(OP_QUERY,    10,    10,    20,    20);
    push_item(OP_QUERY,     0,     0,    -1,     5);
    push_item(OP_QUERY,     0,     0,  4095,    10);
    push_item(OP_QUERY,     5,     5,    10, -4096);
    push_item(OP_QUERY,     5,     5,    10,  4095);
    push_item(OP_QUERY, -4096, -4096,  4094,  4094);
    push_item(OP_ADD,     100,   100,   200,   200);
    push_item(OP_QUERY,   100,   200,   200,   100);  // proper crossing
    push_item(OP_QUERY,   110,   100,   210,   200);  // parallel, no touch
    push_item(OP_QUERY,   150,   150,   250,   250);  // collinear overlap
    push_item(OP_QUERY,   210,   210,   300,   300);  // collinear, disjoint
    push_item(OP_QUERY,   200,   200,   300,   100);  // start on wall end
    push_item(OP_QUERY,   100,   300,   150,   150);  // end on wall interior
    push_item(OP_ADD,     400,   400,   400,   400);  // point wall
    push_item(OP_QUERY,   300,   400,   500,   400);  // passes through point
    push_item(OP_QUERY,   150,   150,   150,   150);  // point move on wall
    push_item(OP_QUERY,    50,    60,    50,    60);  // point move, miss
    push_item(OP_ADD,   -4096,  4095,  4095, -4096);
    push_item(OP_ADD,   -4096, -4096, -4096,  4095);
    push_item(OP_QUERY, -4000,     0,    10,     0);
    push_item(OP_QUERY,  3000,  3000,  3100,  3050);
    push_item(OP_QUERY, -4096,     0,     0,     0);  // starts on left wall
    wait_quiet(8);

    for (int p = 0; p < PHASES; p++) begin
      write_reg(CFG_ARENA_WIDTH,  PH_W[p]);
      write_reg(CFG_ARENA_HEIGHT, PH_H[p]);
      calm = (p % 3 == 2);
      for (int n = 0; n < PH_LEN[p]; n++)
        pending_items = {pending_items, gen_item(PH_W[p], PH_H[p])};
      wait_quiet(8);
    end

    wait_quiet(DRAIN_CYCLES);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Item driver: falling edge; valid holds with a stable payload until taken
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    coord_item_t it;
    if (rst_ni && (!in_valid || in_took)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        it = pending_items.pop_front();
        opcode   <= it.op;
        pa_x     <= it.ax;
        pa_y     <= it.ay;
        pb_x     <= it.bx;
        pb_y     <= it.by;
        in_valid <= 1'b1;
        in_gap   = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver: random stalls, plus one long hold-off while items queue up
  // so the block backs up and drops in_ready.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!hold_done && verdicts_seen >= 100 && pending_items.size() > 20) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready  <= 1'b1;
      stall_left = pick_gap();
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: rising edge. Predicts on each item transaction, checks each result
  // transaction against the oldest verdict, and runs the watchdog.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    coord_item_t it;
    verdict_t    exp_v;
    if (rst_ni) begin
      in_took <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        it.op = opcode;
        it.ax = pa_x;
        it.ay = pa_y;
        it.bx = pb_x;
        it.by = pb_y;
        expected_verdicts = {expected_verdicts, predict_verdict(it)};
      end
      if (out_valid && out_ready) begin
        verdicts_seen++;
        if (expected_verdicts.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected, expected none, actual %b%b%b",
                   $time, collision, out_of_bounds, table_full);
        end else begin
          exp_v = expected_verdicts.pop_front();
          if (collision !== exp_v.collision) begin
            errors++;
            $display("%0t: collision mismatch, expected %b, actual %b", $time,
                     exp_v.collision, collision);
          end
          if (out_of_bounds !== exp_v.out_of_bounds) begin
            errors++;
            $display("%0t: out_of_bounds mismatch, expected %b, actual %b", $time,
                     exp_v.out_of_bounds, out_of_bounds);
          end
          if (table_full !== exp_v.table_full) begin
            errors++;
            $display("%0t: table_full mismatch, expected %b, actual %b", $time,
                     exp_v.table_full, table_full);
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
          $display("Regression FAIL");
          $finish;
        end
      end
    end
  end

endmodule
